@@ design/qf_pkg.sv @@
// qf_pkg: widths, queue item type and saturation bounds for the quadratic fit unit.
// No dependencies.
package qf_pkg;

  localparam int unsigned NA_W   = 35;
  localparam int unsigned NB_W   = 51;
  localparam int unsigned NC_W   = 64;
  localparam int unsigned DEN_W  = 51;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned Q_W    = 32;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = 1;

  localparam int unsigned SH_A = 24;
  localparam int unsigned SH_B = 16;
  localparam int unsigned SH_C = 8;

  localparam logic [Q_W:0] QPOS = {2'b00, {(Q_W-1){1'b1}}};
  localparam logic [Q_W:0] QNEG = {2'b01, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic [NA_W-1:0]  na;
    logic [NB_W-1:0]  nb;
    logic [NC_W-1:0]  nc;
    logic [DEN_W-1:0] den;
    logic             sing;
  } qf_item_t;

endpackage

@@ design/quadratic_fit_three_points_unit.sv @@
// Quadratic fit through three Q8.8 points, coefficients in saturated Q16.16.
// One point set per cycle, busy_o stays low.
// Front: 4 product stages; then the queue; back, per coefficient: operand prep,
// 32 one-bit divider stages, rounding.
// Reset clears all valid bits and queue pointers; the receiver cannot stall.
// Depends on qf_pkg, qf_front, qf_queue, qf_div.
module quadratic_fit_three_points_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] x_first_i,
  input  logic signed [15:0] y_first_i,
  input  logic signed [15:0] x_second_i,
  input  logic signed [15:0] y_second_i,
  input  logic signed [15:0] x_third_i,
  input  logic signed [15:0] y_third_i,
  output logic               done_o,
  output logic signed [31:0] coef_square_o,
  output logic signed [31:0] coef_linear_o,
  output logic signed [31:0] coef_constant_o,
  output logic               singular_o,
  output logic               saturated_o
);
  import qf_pkg::*;

  logic             take, f_valid, q_valid;
  qf_item_t         f_item, q_item;
  logic [NUM_W-1:0] num_a, num_b, num_c;
  logic             va, vb, vc, sa, sb, sc, sat_a, sat_b, sat_c;
  logic [Q_W-1:0]   ca, cb, cc;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  qf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .x_first_i  (x_first_i),
    .y_first_i  (y_first_i),
    .x_second_i (x_second_i),
    .y_second_i (y_second_i),
    .x_third_i  (x_third_i),
    .y_third_i  (y_third_i),
    .valid_o    (f_valid),
    .item_o     (f_item)
  );

  qf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  assign num_a = {{(NUM_W-NA_W){q_item.na[NA_W-1]}}, q_item.na};
  assign num_b = {{(NUM_W-NB_W){q_item.nb[NB_W-1]}}, q_item.nb};
  assign num_c = q_item.nc;

  qf_div #(.SH(SH_A)) u_div_a (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (q_valid), .num_i (num_a),
    .den_i (q_item.den), .sing_i (q_item.sing),
    .valid_o (va), .coef_o (ca), .sing_o (sa), .sat_o (sat_a)
  );

  qf_div #(.SH(SH_B)) u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (q_valid), .num_i (num_b),
    .den_i (q_item.den), .sing_i (q_item.sing),
    .valid_o (vb), .coef_o (cb), .sing_o (sb), .sat_o (sat_b)
  );

  qf_div #(.SH(SH_C)) u_div_c (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (q_valid), .num_i (num_c),
    .den_i (q_item.den), .sing_i (q_item.sing),
    .valid_o (vc), .coef_o (cc), .sing_o (sc), .sat_o (sat_c)
  );

  assign done_o          = va && vb && vc;
  assign coef_square_o   = ca;
  assign coef_linear_o   = cb;
  assign coef_constant_o = cc;
  assign singular_o      = sa && sb && sc;
  assign saturated_o     = sat_a || sat_b || sat_c;

endmodule

@@ design/qf_front.sv @@
// qf_front: four-stage pipeline forming the determinant and the three numerators.
// Depends on qf_pkg.
module qf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic signed [15:0] x_first_i,
  input  logic signed [15:0] y_first_i,
  input  logic signed [15:0] x_second_i,
  input  logic signed [15:0] y_second_i,
  input  logic signed [15:0] x_third_i,
  input  logic signed [15:0] y_third_i,
  output logic               valid_o,
  output qf_pkg::qf_item_t   item_o
);
  import qf_pkg::*;

  logic [3:0] v_q;

  // stage 1
  logic signed [16:0] d12_q, d13_q, d23_q, d31_q;
  logic signed [31:0] sq1_q, sq2_q, sq3_q, p12_q, p23_q, p31_q;
  logic signed [15:0] y1_q, y2_q, y3_q;
  // stage 2
  logic signed [33:0] den2_q;
  logic signed [32:0] e1_q, e2_q, e3_q, ga1_q, ga2_q, ga3_q;
  logic signed [48:0] f1_q, f2_q, f3_q;
  logic signed [16:0] d23b_q;
  logic signed [15:0] y1b_q, y2b_q, y3b_q;
  logic               sing2_q;
  // stage 3
  logic signed [50:0] den3_q;
  logic signed [34:0] na3_q;
  logic signed [48:0] gb1_q, gb2_q, gb3_q;
  logic [63:0]        gc1_q, gc2_q, gc3_q;
  logic               sing3_q;
  logic signed [63:0] gc1, gc2, gc3;
  // stage 4
  logic signed [50:0] nb4;
  logic [63:0]        nc4;
  qf_item_t           item_q;

  assign gc1 = y1b_q * f1_q;
  assign gc2 = y2b_q * f2_q;
  assign gc3 = y3b_q * f3_q;
  assign nb4 = gb1_q + gb2_q + gb3_q;
  assign nc4 = gc1_q + gc2_q + gc3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d12_q <= x_first_i - x_second_i;
    d13_q <= x_first_i - x_third_i;
    d23_q <= x_second_i - x_third_i;
    d31_q <= x_third_i - x_first_i;
    sq1_q <= x_first_i * x_first_i;
    sq2_q <= x_second_i * x_second_i;
    sq3_q <= x_third_i * x_third_i;
    p12_q <= x_first_i * x_second_i;
    p23_q <= x_second_i * x_third_i;
    p31_q <= x_third_i * x_first_i;
    y1_q  <= y_first_i;
    y2_q  <= y_second_i;
    y3_q  <= y_third_i;

    den2_q  <= d12_q * d13_q;
    e1_q    <= sq3_q - sq2_q;
    e2_q    <= sq1_q - sq3_q;
    e3_q    <= sq2_q - sq1_q;
    f1_q    <= p23_q * d23_q;
    f2_q    <= p31_q * d31_q;
    f3_q    <= p12_q * d12_q;
    ga1_q   <= y1_q * d23_q;
    ga2_q   <= y2_q * d31_q;
    ga3_q   <= y3_q * d12_q;
    d23b_q  <= d23_q;
    y1b_q   <= y1_q;
    y2b_q   <= y2_q;
    y3b_q   <= y3_q;
    sing2_q <= (d12_q == '0) || (d13_q == '0) || (d23_q == '0);

    den3_q  <= den2_q * d23b_q;
    na3_q   <= ga1_q + ga2_q + ga3_q;
    gb1_q   <= y1b_q * e1_q;
    gb2_q   <= y2b_q * e2_q;
    gb3_q   <= y3b_q * e3_q;
    gc1_q   <= gc1;
    gc2_q   <= gc2;
    gc3_q   <= gc3;
    sing3_q <= sing2_q;

    item_q.na   <= na3_q;
    item_q.nb   <= nb4;
    item_q.nc   <= nc4;
    item_q.den  <= den3_q;
    item_q.sing <= sing3_q;
  end

  assign valid_o = v_q[3];
  assign item_o  = item_q;

endmodule

@@ design/qf_queue.sv @@
// qf_queue: short FIFO between the front pipeline and the divider lanes.
// Depends on qf_pkg.
module qf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qf_pkg::qf_item_t item_i,
  output logic             valid_o,
  output qf_pkg::qf_item_t item_o
);
  import qf_pkg::*;

  qf_item_t         mem_q [QDEPTH];
  qf_item_t         item_q;
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             vld_q;
  logic             pop;

  assign pop = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= pop;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
    if (pop) begin
      item_q <= mem_q[rd_q];
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop && (cnt_q == (PTR_W+1)'(QDEPTH))))
    else $error("queue transfer into full queue");

endmodule

@@ design/qf_div.sv @@
// qf_div: one divider lane, restoring division one quotient bit per stage,
// round half away from zero and saturation to Q16.16. Depends on qf_pkg.
module qf_div #(
  parameter int unsigned SH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [qf_pkg::NUM_W-1:0] num_i,
  input  logic [qf_pkg::DEN_W-1:0] den_i,
  input  logic                     sing_i,
  output logic                     valid_o,
  output logic [qf_pkg::Q_W-1:0]   coef_o,
  output logic                     sing_o,
  output logic                     sat_o
);
  import qf_pkg::*;

  localparam int unsigned N_W = NUM_W + SH;

  logic             v0_q, neg0_q, sing0_q;
  logic [NUM_W-1:0] un0_q;
  logic [DEN_W-1:0] ud0_q;
  logic [N_W-1:0]   nwide, nhigh;

  logic [Q_W:0]     v_q, neg_q, sing_q, ovf_q;
  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [DEN_W-1:0] ud_q  [Q_W+1];
  logic [Q_W-1:0]   q_q   [Q_W+1];
  logic [Q_W-1:0]   low_q [Q_W+1];

  logic             round_up, sat;
  logic [Q_W:0]     qr;
  logic [Q_W-1:0]   coef;

  logic             vo_q, so_q, sat_q;
  logic [Q_W-1:0]   coef_q;

  assign nwide = {un0_q, {SH{1'b0}}};
  assign nhigh = nwide >> Q_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v_q  <= {v_q[Q_W-1:0], v0_q};
      vo_q <= v_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    neg0_q    <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    un0_q     <= num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
    ud0_q     <= den_i[DEN_W-1] ? (~den_i + 1'b1) : den_i;
    sing0_q   <= sing_i;

    rem_q[0]  <= DEN_W'(nhigh);
    low_q[0]  <= nwide[Q_W-1:0];
    ud_q[0]   <= ud0_q;
    q_q[0]    <= '0;
    ovf_q[0]  <= (nhigh >= N_W'(ud0_q));
    neg_q[0]  <= neg0_q;
    sing_q[0] <= sing0_q;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W:0] r2;
    logic           ge;
    assign r2 = {rem_q[s], low_q[s][Q_W-1-s]};
    assign ge = (r2 >= {1'b0, ud_q[s]});
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? DEN_W'(r2 - {1'b0, ud_q[s]}) : r2[DEN_W-1:0];
      q_q[s+1]    <= {q_q[s][Q_W-2:0], ge};
      low_q[s+1]  <= low_q[s];
      ud_q[s+1]   <= ud_q[s];
      ovf_q[s+1]  <= ovf_q[s];
      neg_q[s+1]  <= neg_q[s];
      sing_q[s+1] <= sing_q[s];
    end
  end

  always_comb begin
    round_up = ({rem_q[Q_W], 1'b0} >= {1'b0, ud_q[Q_W]});
    qr       = {1'b0, q_q[Q_W]} + (Q_W+1)'(round_up);
    sat      = ovf_q[Q_W] || (neg_q[Q_W] ? (qr > QNEG) : (qr > QPOS));
    if (sat) begin
      coef = neg_q[Q_W] ? QNEG[Q_W-1:0] : QPOS[Q_W-1:0];
    end else begin
      coef = neg_q[Q_W] ? (~qr[Q_W-1:0] + 1'b1) : qr[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    so_q   <= sing_q[Q_W];
    sat_q  <= sat && !sing_q[Q_W];
    coef_q <= sing_q[Q_W] ? '0 : coef;
  end

  assign valid_o = vo_q;
  assign coef_o  = coef_q;
  assign sing_o  = so_q;
  assign sat_o   = sat_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && so_q) |-> (coef_q == '0) && !sat_q)
    else $error("singular result not zero");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && sat_q) |-> (coef_q == QPOS[Q_W-1:0]) || (coef_q == QNEG[Q_W-1:0]))
    else $error("saturated result off bound");

  a_lane_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> ##(Q_W+2) vo_q)
    else $error("lane dropped a result");

endmodule
